// ===== rtl/mbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Types, register codes and constants shared by the masked byte pattern scan.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int PatternBytesMax = 48;
  localparam int PatternWords    = 6;
  localparam int WordW           = 64;
  localparam int ByteW           = 8;
  localparam int MaskW           = 48;
  localparam int AddrW           = 64;
  localparam int CountW          = 64;
  localparam int RegIdxW         = 3;
  localparam int CfgDataW        = 64;

  typedef enum logic [RegIdxW-1:0] {
    REG_PATTERN_0   = 3'd0,
    REG_PATTERN_1   = 3'd1,
    REG_PATTERN_2   = 3'd2,
    REG_PATTERN_3   = 3'd3,
    REG_PATTERN_4   = 3'd4,
    REG_PATTERN_5   = 3'd5,
    REG_BYTE_MASK   = 3'd6,
    REG_REGION_BASE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_region;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } out_t;

  // Register file contents as seen by the datapath. The base is stored with
  // the signature length less one already taken off, so a window end maps to its
  // start address with one add.
  typedef struct packed {
    logic [PatternWords-1:0][WordW-1:0] pattern;
    logic [MaskW-1:0]                   mask;
    logic [AddrW-1:0]                   base_adj;
  } cfg_t;

  // Control of the item held after the window stage.
  typedef struct packed {
    logic valid;
    logic last;
    logic full;
  } s1_ctrl_t;

endpackage

// ===== rtl/mbps_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration registers: signature words, byte mask and region base.
// ----------------------------------------------------------------------------
module mbps_cfg_regs
  import mbps_pkg::*;
#(
  parameter int PATTERN_BYTES = PatternBytesMax
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  localparam logic [AddrW-1:0] StartLag  = AddrW'(PATTERN_BYTES - 1);
  localparam logic [AddrW-1:0] BaseAdjRst = AddrW'(0) - StartLag;

  logic [PatternWords-1:0][WordW-1:0] pattern_q;
  logic [MaskW-1:0]                   mask_q;
  logic [AddrW-1:0]                   base_adj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      mask_q     <= '1;
      base_adj_q <= BaseAdjRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i)) inside
        REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2,
        REG_PATTERN_3, REG_PATTERN_4, REG_PATTERN_5: begin
          pattern_q[cfg_idx_i] <= cfg_wdata_i[WordW-1:0];
        end
        REG_BYTE_MASK: begin
          mask_q <= cfg_wdata_i[MaskW-1:0];
        end
        REG_REGION_BASE: begin
          base_adj_q <= cfg_wdata_i[AddrW-1:0] - StartLag;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.pattern  = pattern_q;
  assign cfg_o.mask     = mask_q;
  assign cfg_o.base_adj = base_adj_q;

endmodule

// ===== rtl/mbps_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_window
// Input stage: sliding byte window, region byte count and the start address
// of the window that ends on the newest byte.
// ----------------------------------------------------------------------------
module mbps_window
  import mbps_pkg::*;
#(
  parameter int PATTERN_BYTES = PatternBytesMax
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_accept_i,
  input  in_t                                 in_data_i,
  input  logic                                adv_i,
  input  logic [AddrW-1:0]                    base_adj_i,
  output logic [PATTERN_BYTES-1:0][ByteW-1:0] window_o,
  output s1_ctrl_t                            s1_o,
  output logic [AddrW-1:0]                    cand_addr_o
);

  localparam logic [CountW-1:0] CountMax  = '1;
  localparam logic [CountW-1:0] FullLimit = CountW'(PATTERN_BYTES - 1);

  logic [PATTERN_BYTES-1:0][ByteW-1:0] window_q, window_d;
  logic [CountW-1:0]                   count_q, count_d, count_eff;
  logic                                valid_q, valid_d;
  logic                                last_q, full_q;
  logic [AddrW-1:0]                    cand_q;
  logic                                count_sat;

  always_comb begin
    for (int j = 0; j < PATTERN_BYTES - 1; j++) begin
      window_d[j] = window_q[j+1];
    end
    window_d[PATTERN_BYTES-1] = in_data_i.data_byte;
  end

  // The count sticks at its top value; the offset added to the base then stays
  // one below it.
  assign count_sat = (count_q == CountMax);
  assign count_eff = count_sat ? (CountMax - CountW'(1)) : count_q;

  always_comb begin
    count_d = count_q;
    if (in_accept_i) begin
      if (in_data_i.end_of_region) begin
        count_d = '0;
      end else if (!count_sat) begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_accept_i) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      window_q <= window_d;
      last_q   <= in_data_i.end_of_region;
      full_q   <= (count_q >= FullLimit);
      cand_q   <= base_adj_i + count_eff;
    end
  end

  assign window_o    = window_q;
  assign s1_o.valid  = valid_q;
  assign s1_o.last   = last_q;
  assign s1_o.full   = full_q;
  assign cand_addr_o = cand_q;

endmodule

// ===== rtl/mbps_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match
// Masked compare of the whole window against the signature in one pass.
// ----------------------------------------------------------------------------
module mbps_match
  import mbps_pkg::*;
#(
  parameter int PATTERN_BYTES = PatternBytesMax
) (
  input  logic [PATTERN_BYTES-1:0][ByteW-1:0] window_i,
  input  logic [PatternWords-1:0][WordW-1:0]  pattern_i,
  input  logic [MaskW-1:0]                    mask_i,
  output logic                                match_o
);

  logic [PATTERN_BYTES-1:0] byte_ok;

  for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_byte
    localparam int WordSel = j / 8;
    localparam int ByteSel = j % 8;
    logic [ByteW-1:0] sig;
    logic             care;

    assign sig = pattern_i[WordSel][ByteSel*ByteW +: ByteW];
    // The first signature byte anchors the search and is never a wildcard.
    assign care       = (j == 0) ? 1'b1 : mask_i[j];
    assign byte_ok[j] = !care || (window_i[j] == sig);
  end

  assign match_o = &byte_ok;

endmodule

// ===== rtl/masked_byte_pattern_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Streams the bytes of a region and reports the first place where a masked
// byte signature matches, as region base plus offset, on the region's end.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-----------------------
//   in       | input     | in_valid_i / in_stall_o    | in_data_i  (in_t)
//   out      | output    | out_valid_o / out_stall_i  | out_data_o (out_t)
//   cfg      | input     | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// One byte is taken every cycle while in_stall_o is low. A byte passes through
// the window register, then the masked compare and hit update; a region's result
// goes to the output register as its last byte leaves the window register. The
// compare across all signature bytes sets the clock period. Reset clears the
// count, the hit and both valid flags; no clearing pass follows. in_stall_o is
// high only while a region's last byte waits for the output register to be freed.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int PATTERN_BYTES = PatternBytesMax
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t                                cfg;
  s1_ctrl_t                            s1;
  logic [PATTERN_BYTES-1:0][ByteW-1:0] window;
  logic [AddrW-1:0]                    cand_addr;
  logic                                match;

  logic             in_accept;
  logic             out_free;
  logic             s1_adv;
  logic             hit;
  logic             seen_d;
  logic [AddrW-1:0] addr_d;

  logic             hit_seen_q;
  logic [AddrW-1:0] hit_addr_q;
  logic             out_valid_q;
  out_t             out_data_q;

  mbps_cfg_regs #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  mbps_window #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_accept_i(in_accept),
    .in_data_i  (in_data_i),
    .adv_i      (s1_adv),
    .base_adj_i (cfg.base_adj),
    .window_o   (window),
    .s1_o       (s1),
    .cand_addr_o(cand_addr)
  );

  mbps_match #(
    .PATTERN_BYTES(PATTERN_BYTES)
  ) u_match (
    .window_i (window),
    .pattern_i(cfg.pattern),
    .mask_i   (cfg.mask),
    .match_o  (match)
  );

  // Only a region's last byte needs the output register; all other bytes
  // move on regardless of the output side.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1.valid && (!s1.last || out_free);
  assign in_stall_o = s1.valid && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign hit    = s1.full && match;
  assign seen_d = hit_seen_q || hit;
  assign addr_d = hit_seen_q ? hit_addr_q : cand_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        hit_seen_q <= s1.last ? 1'b0 : seen_d;
      end
      if (s1_adv && s1.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1.last) begin
      hit_addr_q <= addr_d;
    end
    if (s1_adv && s1.last) begin
      out_data_q.found         <= seen_d;
      out_data_q.match_address <= seen_d ? addr_d : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_stall_needs_item: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1.valid && s1.last && out_valid_q)
  ) else $error("input stalled without a pending region end");

  a_hit_cleared_at_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1.last) |=> !hit_seen_q
  ) else $error("hit state survived a region end");

  a_no_hit_before_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1.last && !s1.full && !hit_seen_q) |=> !hit_seen_q
  ) else $error("hit recorded before the window filled");

  a_miss_gives_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.match_address == '0)
  ) else $error("address not zero on a region without a match");

endmodule
